[src/hldf_pkg.sv]
// shared types and constants for the header/length/xor deframer
`timescale 1ns / 1ps

package hldf_pkg;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_GOT_U   = 3'd1;
    localparam logic [2:0] PH_GOT_N   = 3'd2;
    localparam logic [2:0] PH_GOT_E   = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_TOKEN   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [7:0] HDR0 = 8'h55;
    localparam logic [7:0] HDR1 = 8'h4E;
    localparam logic [7:0] HDR2 = 8'h45;
    localparam logic [7:0] HDR3 = 8'h52;
    localparam logic [7:0] SEP  = 8'h3A;
    localparam logic [7:0] HDR_XOR = HDR0 ^ HDR1 ^ HDR2 ^ HDR3 ^ SEP;

    localparam logic [7:0] IDLE_RELOAD_RST = 8'd6;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       frame_good;
        logic [7:0] frame_length;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] bytes_left;
    } t_status;

endpackage

[src/hldf_in_stage.sv]
// input register stage with stall toward the sender
`timescale 1ns / 1ps

module hldf_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hldf_pkg::t_item     i_item,
    input  logic                i_consume,
    output logic                o_valid,
    output hldf_pkg::t_item     o_item
);

    logic            r_valid;
    hldf_pkg::t_item r_item;

    assign o_stall = r_valid && !i_consume;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[src/hldf_parser.sv]
// frame parser state, checksum, idle timeout and config register
`timescale 1ns / 1ps

module hldf_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_fire,
    input  hldf_pkg::t_item     i_item,
    output logic                o_res_valid,
    output hldf_pkg::t_result   o_res,
    output hldf_pkg::t_status   o_status
);

    logic [7:0] r_reload;
    logic [2:0] r_phase;
    logic [7:0] r_bytes_left;
    logic [7:0] r_frame_len;
    logic [7:0] r_xor;
    logic [7:0] r_idle;

    logic [2:0] n_phase;
    logic [7:0] n_bytes_left;
    logic [7:0] n_frame_len;
    logic [7:0] n_xor;
    logic [7:0] n_idle;

    logic [7:0] b;
    logic [2:0] hunt_phase;

    assign b          = i_item.rx_byte;
    assign hunt_phase = (b == hldf_pkg::HDR0) ? hldf_pkg::PH_GOT_U : hldf_pkg::PH_HUNT;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_frame_len  = r_frame_len;
        n_xor        = r_xor;
        n_idle       = r_idle;
        o_res_valid  = 1'b0;
        o_res.out_byte     = b;
        o_res.out_last     = 1'b0;
        o_res.frame_good   = 1'b0;
        o_res.frame_length = r_frame_len;
        if (i_fire) begin
            if (i_item.cmd == hldf_pkg::CMD_TICK) begin
                if (r_idle != 8'd0) begin
                    n_idle = r_idle - 8'd1;
                    if (r_idle == 8'd1) begin
                        n_phase = hldf_pkg::PH_HUNT;
                    end
                end
            end else begin
                n_idle = r_reload;
                case (r_phase)
                    hldf_pkg::PH_HUNT: begin
                        n_phase = hunt_phase;
                    end
                    hldf_pkg::PH_GOT_U: begin
                        n_phase = (b == hldf_pkg::HDR1) ? hldf_pkg::PH_GOT_N : hunt_phase;
                    end
                    hldf_pkg::PH_GOT_N: begin
                        n_phase = (b == hldf_pkg::HDR2) ? hldf_pkg::PH_GOT_E : hunt_phase;
                    end
                    hldf_pkg::PH_GOT_E: begin
                        n_phase = (b == hldf_pkg::HDR3) ? hldf_pkg::PH_LEN : hunt_phase;
                    end
                    hldf_pkg::PH_LEN: begin
                        if (b == 8'd0) begin
                            n_phase = hldf_pkg::PH_HUNT;
                        end else begin
                            n_frame_len = b;
                            n_phase     = hldf_pkg::PH_TOKEN;
                        end
                    end
                    hldf_pkg::PH_TOKEN: begin
                        if (b == hldf_pkg::SEP) begin
                            n_xor        = hldf_pkg::HDR_XOR ^ r_frame_len;
                            n_bytes_left = r_frame_len;
                            n_phase      = hldf_pkg::PH_PAYLOAD;
                        end else begin
                            n_phase = hunt_phase;
                        end
                    end
                    hldf_pkg::PH_PAYLOAD: begin
                        o_res_valid = 1'b1;
                        if (r_bytes_left > 8'd1) begin
                            n_xor        = r_xor ^ b;
                            n_bytes_left = r_bytes_left - 8'd1;
                        end else begin
                            n_bytes_left     = 8'd0;
                            n_phase          = hldf_pkg::PH_HUNT;
                            o_res.out_last   = 1'b1;
                            o_res.frame_good = (r_xor == b);
                        end
                    end
                    default: begin
                        n_phase = hldf_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload     <= hldf_pkg::IDLE_RELOAD_RST;
            r_phase      <= hldf_pkg::PH_HUNT;
            r_bytes_left <= 8'd0;
            r_frame_len  <= 8'd0;
            r_xor        <= 8'd0;
            r_idle       <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_reload <= i_cfg_wdata;
            end
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_frame_len  <= n_frame_len;
            r_xor        <= n_xor;
            r_idle       <= n_idle;
        end
    end

    assign o_status.phase      = r_phase;
    assign o_status.bytes_left = r_bytes_left;

endmodule

[src/hldf_out_stage.sv]
// result register toward the receiver
`timescale 1ns / 1ps

module hldf_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_valid,
    input  hldf_pkg::t_result   i_load,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_stall,
    output hldf_pkg::t_result   o_res
);

    logic              r_valid;
    hldf_pkg::t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load_valid) begin
            r_res <= i_load;
        end
    end

endmodule

[src/header_length_xor_deframer.sv]
// path: a byte transfer passes the input reg, the combinational parser, then the result reg (loaded only when free)
// throughput: one item per cycle while the receiver does not stall, set by the single-pass parser between the two regs
// ticks and header bytes give no result but still pass through the parser and need a free result reg
// reset: synchronous active low, parser hunts for a frame start, timeout reload is 6
// reset clears both stage valids, so nothing is shown until a new frame arrives
`timescale 1ns / 1ps

module header_length_xor_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_frame_good,
    output logic [7:0] o_frame_length,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    hldf_pkg::t_item   in_item;
    hldf_pkg::t_item   stage_item;
    hldf_pkg::t_result res;
    hldf_pkg::t_result out_res;
    hldf_pkg::t_status status;
    logic              stage_valid;
    logic              out_free;
    logic              fire;
    logic              res_valid;

    assign in_item.cmd     = i_cmd;
    assign in_item.rx_byte = i_rx_byte;
    assign fire            = stage_valid && out_free;

    hldf_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_consume (fire),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    hldf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_status    (status)
    );

    hldf_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (res_valid),
        .i_load       (res),
        .o_free       (out_free),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_res        (out_res)
    );

    assign o_out_byte     = out_res.out_byte;
    assign o_out_last     = out_res.out_last;
    assign o_frame_good   = out_res.frame_good;
    assign o_frame_length = out_res.frame_length;

`ifndef SYNTH
    // results only come from a frame in its payload with bytes still due
    a_res_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (status.phase == hldf_pkg::PH_PAYLOAD && status.bytes_left != 8'd0))
        else $error("result outside payload");

    // input side stalls only while the input reg holds an item not moving on
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (stage_valid && !out_free))
        else $error("stall without full stages");

    // the last byte of a frame sends the parser back to hunting
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && out_free && res.out_last) |=> (status.phase == hldf_pkg::PH_HUNT))
        else $error("frame not closed after last byte");

    // nothing is shown right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
